// File: design/stable_priority_ready_queue_macros.svh
// Assertion macros used by the checker file of the ready queue.
// No dependencies.
`ifndef STABLE_PRIORITY_READY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_READY_QUEUE_MACROS_SVH

// Checked only outside reset.
`define SPRQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPRQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/sprq_pkg.sv
// Types and codes for the stable priority ready queue.
// No dependencies; used by every RTL and checker file.
package sprq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  priority_lvl;
      logic [15:0] deadline;
   } entry_type;

   // Broadcast to every cell in a cycle
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type item;
   } cell_op_type;

   // Ordering key: priority above time limit
   function automatic logic [23:0] entry_key(input entry_type e);
      entry_key = {e.priority_lvl, e.deadline};
   endfunction

endpackage

// File: design/stable_priority_ready_queue.sv
// Top level of the stable priority ready queue: cell chain, count, result register.
// Depends on sprq_pkg and sprq_cell.
//
//   Channel  Dir  Handshake             Payload
//   req_     in   req_valid/req_ready   command, tag, priority, time limit
//   rsp_     out  rsp_valid/rsp_ready   got_entry, entry fields, status, occupancy
//
// One transaction per cycle while req_ready is high: every cell compares its key
// with the broadcast entry in parallel and all cells shift together, so an insert
// or remove completes in the cycle it is accepted; the result is registered and appears in the following cycle.
// req_ready is high while the result register is empty or being drained.
// Synchronous reset empties the queue; no clearing pass.
module stable_priority_ready_queue #(
   parameter int QUEUE_DEPTH = sprq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_item_tag,
   input  logic [7:0]  req_item_priority,
   input  logic [15:0] req_item_time_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_got_entry,
   output logic [15:0] rsp_out_tag,
   output logic [7:0]  rsp_out_priority,
   output logic [15:0] rsp_out_time_limit,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_occupancy
);
   import sprq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          got_ff, got_in;
   entry_type     out_ff, out_in;
   logic [1:0]    status_ff, status_in;
   logic [4:0]    occ_ff, occ_in;

   logic          accept, is_full, is_empty;
   cell_op_type   op;
   entry_type     new_item;
   logic [CW+4:0] occ_wide;

   logic      gt_w    [QUEUE_DEPTH];
   entry_type entry_w [QUEUE_DEPTH];
   logic      valid_w [QUEUE_DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CW'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);

   assign new_item.tag          = req_item_tag;
   assign new_item.priority_lvl = req_item_priority;
   assign new_item.deadline     = req_item_time_limit;

   assign op.ins  = accept && (req_command == CMD_INSERT) && !is_full;
   assign op.rem  = accept && (req_command == CMD_REMOVE) && !is_empty;
   assign op.item = new_item;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         sprq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (op),
            .left_gt     ((i == 0) ? 1'b0 : gt_w[(i == 0) ? 0 : i - 1]),
            .left_entry  (entry_w[(i == 0) ? 0 : i - 1]),
            .left_valid  ((i == 0) ? 1'b0 : valid_w[(i == 0) ? 0 : i - 1]),
            .right_entry (entry_w[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .right_valid ((i == QUEUE_DEPTH - 1) ? 1'b0
                          : valid_w[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .gt          (gt_w[i]),
            .entry       (entry_w[i]),
            .valid       (valid_w[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + CW'(1);
      end else if (op.rem) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign occ_wide = {5'b0, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      got_in       = got_ff;
      out_in       = out_ff;
      status_in    = status_ff;
      occ_in       = occ_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         got_in       = op.rem;
         out_in       = op.rem ? entry_w[0] : '0;
         occ_in       = occ_wide[4:0];
         if (req_command == CMD_INSERT) begin
            status_in = is_full ? ST_FULL : ST_DONE;
         end else begin
            status_in = is_empty ? ST_EMPTY : ST_DONE;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      got_ff    <= got_in;
      out_ff    <= out_in;
      status_ff <= status_in;
      occ_ff    <= occ_in;
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_got_entry      = got_ff;
   assign rsp_out_tag        = out_ff.tag;
   assign rsp_out_priority   = out_ff.priority_lvl;
   assign rsp_out_time_limit = out_ff.deadline;
   assign rsp_status         = status_ff;
   assign rsp_occupancy      = occ_ff;

endmodule

// File: design/sprq_cell.sv
// One slot of the sorted shift-cell queue.
// Depends on sprq_pkg.
module sprq_cell (
   input  logic                clock,
   input  logic                reset,
   input  sprq_pkg::cell_op_type op,
   input  logic                left_gt,
   input  sprq_pkg::entry_type left_entry,
   input  logic                left_valid,
   input  sprq_pkg::entry_type right_entry,
   input  logic                right_valid,
   output logic                gt,
   output sprq_pkg::entry_type entry,
   output logic                valid
);
   import sprq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // An empty slot ranks behind everything; equal keys stay ahead of the new one
   assign gt = !valid_ff || (entry_key(entry_ff) > entry_key(op.item));

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (op.rem) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else if (op.ins && gt) begin
         if (left_gt) begin
            entry_in = left_entry;
            valid_in = left_valid;
         end else begin
            entry_in = op.item;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

// File: design/sprq_checker.sv
// Port-level checks for the stable priority ready queue, bound to the top level.
// Depends on sprq_pkg and stable_priority_ready_queue_macros.svh.
`include "stable_priority_ready_queue_macros.svh"

module sprq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_got_entry,
   input logic [15:0] rsp_out_tag,
   input logic [1:0]  rsp_status,
   input logic [4:0]  rsp_occupancy
);
   import sprq_pkg::*;

   `SPRQ_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_tag) && $stable(rsp_status),
      "stalled result changed")

   `SPRQ_ASSERT(a_entry_done, clock, reset,
      rsp_valid && rsp_got_entry |-> rsp_status == ST_DONE,
      "returned entry with error status")

   `SPRQ_ASSERT(a_empty_zero, clock, reset,
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_occupancy == 5'd0 && !rsp_got_entry && rsp_out_tag == 16'd0,
      "empty remove result malformed")

   // every accepted transaction leaves a result behind
   `SPRQ_ASSERT(a_accept_result, clock, reset,
      req_valid && req_ready |=> rsp_valid,
      "accepted transaction produced no result")

   `SPRQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready,
      "result pending after reset")

endmodule

bind stable_priority_ready_queue sprq_checker u_sprq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_got_entry (rsp_got_entry),
   .rsp_out_tag   (rsp_out_tag),
   .rsp_status    (rsp_status),
   .rsp_occupancy (rsp_occupancy)
);
